@@ rtl/core/mips32_decode_alias_classifier_assert.svh @@
// Assertion macros for the MIPS32 decode and alias classifier.
// Define NO_ASSERTIONS to compile every check away.
`ifndef MIPS32_DECODE_ALIAS_CLASSIFIER_ASSERT_SVH
`define MIPS32_DECODE_ALIAS_CLASSIFIER_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define MDAC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

`define MDAC_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define MDAC_ASSERT(label, clk, rst, prop, msg)

`define MDAC_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

@@ rtl/core/mdac_pkg.sv @@
// Package for the MIPS32 decode and alias classifier: field widths,
// opcode and function codes, mnemonic numbers, alias codes and lookups.
`default_nettype none

package mdac_pkg;

   localparam int unsigned WORD_W     = 32;
   localparam int unsigned MNEMONIC_W = 6;
   localparam int unsigned ALIAS_W    = 3;
   localparam int unsigned REG_W      = 5;
   localparam int unsigned IMM_W      = 16;
   localparam int unsigned TARGET_W   = 28;
   localparam int unsigned CODE_W     = 6;

   typedef logic [MNEMONIC_W-1:0] mnemonic_type;
   typedef logic [ALIAS_W-1:0]    alias_type;
   typedef logic [REG_W-1:0]      reg_type;
   typedef logic [CODE_W-1:0]     code_type;

   // primary opcodes
   localparam code_type OP_SPECIAL = 6'h00;
   localparam code_type OP_J       = 6'h02;
   localparam code_type OP_JAL     = 6'h03;
   localparam code_type OP_BEQ     = 6'h04;
   localparam code_type OP_BNE     = 6'h05;
   localparam code_type OP_ADDI    = 6'h08;
   localparam code_type OP_ADDIU   = 6'h09;
   localparam code_type OP_SLTI    = 6'h0A;
   localparam code_type OP_ANDI    = 6'h0C;
   localparam code_type OP_ORI     = 6'h0D;
   localparam code_type OP_LUI     = 6'h0F;
   localparam code_type OP_LB      = 6'h20;
   localparam code_type OP_LH      = 6'h21;
   localparam code_type OP_LW      = 6'h23;
   localparam code_type OP_LBU     = 6'h24;
   localparam code_type OP_LHU     = 6'h25;
   localparam code_type OP_SB      = 6'h28;
   localparam code_type OP_SH      = 6'h29;
   localparam code_type OP_SW      = 6'h2B;

   // special function codes
   localparam code_type FN_SLL   = 6'h00;
   localparam code_type FN_SRL   = 6'h02;
   localparam code_type FN_SRA   = 6'h03;
   localparam code_type FN_JR    = 6'h08;
   localparam code_type FN_MFHI  = 6'h10;
   localparam code_type FN_MTHI  = 6'h11;
   localparam code_type FN_MFLO  = 6'h12;
   localparam code_type FN_MTLO  = 6'h13;
   localparam code_type FN_MULT  = 6'h18;
   localparam code_type FN_MULTU = 6'h19;
   localparam code_type FN_DIV   = 6'h1A;
   localparam code_type FN_DIVU  = 6'h1B;
   localparam code_type FN_ADD   = 6'h20;
   localparam code_type FN_ADDU  = 6'h21;
   localparam code_type FN_SUB   = 6'h22;
   localparam code_type FN_SUBU  = 6'h23;
   localparam code_type FN_AND   = 6'h24;
   localparam code_type FN_OR    = 6'h25;
   localparam code_type FN_XOR   = 6'h26;
   localparam code_type FN_NOR   = 6'h27;
   localparam code_type FN_SLT   = 6'h2A;

   // dense mnemonic numbers
   localparam mnemonic_type MN_SLL     = 6'd0;
   localparam mnemonic_type MN_SRL     = 6'd1;
   localparam mnemonic_type MN_SRA     = 6'd2;
   localparam mnemonic_type MN_JR      = 6'd3;
   localparam mnemonic_type MN_MFHI    = 6'd4;
   localparam mnemonic_type MN_MTHI    = 6'd5;
   localparam mnemonic_type MN_MFLO    = 6'd6;
   localparam mnemonic_type MN_MTLO    = 6'd7;
   localparam mnemonic_type MN_MULT    = 6'd8;
   localparam mnemonic_type MN_MULTU   = 6'd9;
   localparam mnemonic_type MN_DIV     = 6'd10;
   localparam mnemonic_type MN_DIVU    = 6'd11;
   localparam mnemonic_type MN_ADD     = 6'd12;
   localparam mnemonic_type MN_ADDU    = 6'd13;
   localparam mnemonic_type MN_SUB     = 6'd14;
   localparam mnemonic_type MN_SUBU    = 6'd15;
   localparam mnemonic_type MN_AND     = 6'd16;
   localparam mnemonic_type MN_OR      = 6'd17;
   localparam mnemonic_type MN_XOR     = 6'd18;
   localparam mnemonic_type MN_NOR     = 6'd19;
   localparam mnemonic_type MN_SLT     = 6'd20;
   localparam mnemonic_type MN_BEQ     = 6'd21;
   localparam mnemonic_type MN_BNE     = 6'd22;
   localparam mnemonic_type MN_ADDI    = 6'd23;
   localparam mnemonic_type MN_ADDIU   = 6'd24;
   localparam mnemonic_type MN_SLTI    = 6'd25;
   localparam mnemonic_type MN_ANDI    = 6'd26;
   localparam mnemonic_type MN_ORI     = 6'd27;
   localparam mnemonic_type MN_LUI     = 6'd28;
   localparam mnemonic_type MN_LB      = 6'd29;
   localparam mnemonic_type MN_LH      = 6'd30;
   localparam mnemonic_type MN_LW      = 6'd31;
   localparam mnemonic_type MN_LBU     = 6'd32;
   localparam mnemonic_type MN_LHU     = 6'd33;
   localparam mnemonic_type MN_SB      = 6'd34;
   localparam mnemonic_type MN_SH      = 6'd35;
   localparam mnemonic_type MN_SW      = 6'd36;
   localparam mnemonic_type MN_J       = 6'd37;
   localparam mnemonic_type MN_JAL     = 6'd38;
   localparam mnemonic_type MN_UNKNOWN = 6'd63;

   // pseudo-instruction alias codes
   localparam alias_type ALIAS_NONE  = 3'd0;
   localparam alias_type ALIAS_NOP   = 3'd1;
   localparam alias_type ALIAS_MOVE  = 3'd2;
   localparam alias_type ALIAS_LI    = 3'd3;
   localparam alias_type ALIAS_B     = 3'd4;
   localparam alias_type ALIAS_NOPDS = 3'd5;

   function automatic mnemonic_type special_mnemonic(input code_type funct);
      mnemonic_type mn;
      unique case (funct)
         FN_SLL:   mn = MN_SLL;
         FN_SRL:   mn = MN_SRL;
         FN_SRA:   mn = MN_SRA;
         FN_JR:    mn = MN_JR;
         FN_MFHI:  mn = MN_MFHI;
         FN_MTHI:  mn = MN_MTHI;
         FN_MFLO:  mn = MN_MFLO;
         FN_MTLO:  mn = MN_MTLO;
         FN_MULT:  mn = MN_MULT;
         FN_MULTU: mn = MN_MULTU;
         FN_DIV:   mn = MN_DIV;
         FN_DIVU:  mn = MN_DIVU;
         FN_ADD:   mn = MN_ADD;
         FN_ADDU:  mn = MN_ADDU;
         FN_SUB:   mn = MN_SUB;
         FN_SUBU:  mn = MN_SUBU;
         FN_AND:   mn = MN_AND;
         FN_OR:    mn = MN_OR;
         FN_XOR:   mn = MN_XOR;
         FN_NOR:   mn = MN_NOR;
         FN_SLT:   mn = MN_SLT;
         default:  mn = MN_UNKNOWN;
      endcase
      return mn;
   endfunction

   function automatic mnemonic_type primary_mnemonic(input code_type op);
      mnemonic_type mn;
      unique case (op)
         OP_J:     mn = MN_J;
         OP_JAL:   mn = MN_JAL;
         OP_BEQ:   mn = MN_BEQ;
         OP_BNE:   mn = MN_BNE;
         OP_ADDI:  mn = MN_ADDI;
         OP_ADDIU: mn = MN_ADDIU;
         OP_SLTI:  mn = MN_SLTI;
         OP_ANDI:  mn = MN_ANDI;
         OP_ORI:   mn = MN_ORI;
         OP_LUI:   mn = MN_LUI;
         OP_LB:    mn = MN_LB;
         OP_LH:    mn = MN_LH;
         OP_LW:    mn = MN_LW;
         OP_LBU:   mn = MN_LBU;
         OP_LHU:   mn = MN_LHU;
         OP_SB:    mn = MN_SB;
         OP_SH:    mn = MN_SH;
         OP_SW:    mn = MN_SW;
         default:  mn = MN_UNKNOWN;
      endcase
      return mn;
   endfunction

endpackage

`default_nettype wire

@@ rtl/core/mdac_if.sv @@
// Valid/ready channel interfaces for the MIPS32 decode and alias classifier.
// Depends on mdac_pkg for field widths.
`default_nettype none

interface mdac_req_if
   import mdac_pkg::*;
   ;
   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] instruction;

   modport source (output valid, output instruction, input ready);
   modport sink   (input valid, input instruction, output ready);
endinterface

interface mdac_rsp_if
   import mdac_pkg::*;
   ;
   logic                    valid;
   logic                    ready;
   logic                    recognised;
   logic [MNEMONIC_W-1:0]   mnemonic;
   logic [ALIAS_W-1:0]      alias_kind;
   logic [REG_W-1:0]        alias_dest;
   logic [REG_W-1:0]        alias_source;
   logic [REG_W-1:0]        reg_s;
   logic [REG_W-1:0]        reg_t;
   logic [REG_W-1:0]        reg_d;
   logic [REG_W-1:0]        shift_amount;
   logic signed [IMM_W-1:0] immediate;
   logic [TARGET_W-1:0]     jump_target;

   modport source (
      output valid, output recognised, output mnemonic, output alias_kind,
      output alias_dest, output alias_source, output reg_s, output reg_t,
      output reg_d, output shift_amount, output immediate, output jump_target,
      input ready
   );
   modport sink (
      input valid, input recognised, input mnemonic, input alias_kind,
      input alias_dest, input alias_source, input reg_s, input reg_t,
      input reg_d, input shift_amount, input immediate, input jump_target,
      output ready
   );
endinterface

`default_nettype wire

@@ rtl/core/mips32_decode_alias_classifier.sv @@
// MIPS32 decode and alias classifier, top level.
// Depends on mdac_pkg, mdac_if and mips32_decode_alias_classifier_assert.svh.
//
// Usage:
//   req_chan carries one 32-bit instruction word per beat; rsp_chan returns
//   one decoded beat per request, in order: recognised flag, mnemonic number,
//   pseudo-instruction alias with its registers, and the raw field slices.
//   Unsupported words come back with recognised, mnemonic and alias all zero.
// Datapath: a word accepted on req_chan is held in the input register, decoded,
//   and then held in the result register, which drives rsp_chan.
// Throughput: one beat per cycle while rsp_chan.ready stays high; the decode is
//   one pass of shallow table and compare logic between the two registers.
// Reset: synchronous, active high; both register stages empty, rsp valid low.
// Stall: while rsp_chan.ready is low the result register holds its beat and
//   the input register still takes one more word; req_chan.ready drops only
//   when both stages are full.
`default_nettype none
`include "mips32_decode_alias_classifier_assert.svh"

module mips32_decode_alias_classifier
   import mdac_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   mdac_req_if.sink    req_chan,
   mdac_rsp_if.source  rsp_chan
);

   logic              s1_valid_ff, s1_valid_in;
   logic [WORD_W-1:0] instr_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              req_fire, rsp_load;

   logic                    recognised_ff, recognised_in;
   mnemonic_type            mnemonic_ff, mnemonic_in;
   alias_type               alias_kind_ff, alias_kind_in;
   reg_type                 alias_dest_ff, alias_dest_in;
   reg_type                 alias_source_ff, alias_source_in;
   reg_type                 reg_s_ff, reg_t_ff, reg_d_ff, shift_amount_ff;
   logic signed [IMM_W-1:0] immediate_ff;
   logic [TARGET_W-1:0]     jump_target_ff, jump_target_in;

   code_type     op, funct;
   reg_type      rs, rt, rd, sh;
   logic         imm_zero;
   mnemonic_type mn;
   logic         known;

   assign rsp_load       = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = !s1_valid_ff || rsp_load;
   assign req_fire       = req_chan.valid && req_chan.ready;

   assign s1_valid_in  = req_fire || (s1_valid_ff && !rsp_load);
   assign rsp_valid_in = rsp_load ? s1_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         instr_ff <= req_chan.instruction;
      end
   end

   assign op       = instr_ff[31:26];
   assign rs       = instr_ff[25:21];
   assign rt       = instr_ff[20:16];
   assign rd       = instr_ff[15:11];
   assign sh       = instr_ff[10:6];
   assign funct    = instr_ff[5:0];
   assign imm_zero = (instr_ff[15:0] == '0);

   assign mn    = (op == OP_SPECIAL) ? special_mnemonic(funct) : primary_mnemonic(op);
   assign known = (mn != MN_UNKNOWN);

   assign recognised_in  = known;
   assign mnemonic_in    = known ? mn : '0;
   assign jump_target_in = {instr_ff[25:0], 2'b00};

   always_comb begin
      alias_kind_in   = ALIAS_NONE;
      alias_dest_in   = '0;
      alias_source_in = '0;
      unique case (mn)
         MN_SLL, MN_SRL, MN_SRA: begin
            priority if (rd == '0) begin
               alias_kind_in = ALIAS_NOP;
            end else if (rt == '0) begin
               alias_kind_in = ALIAS_MOVE;
               alias_dest_in = rd;
            end else begin
               alias_kind_in = ALIAS_NONE;
            end
         end
         MN_MFHI, MN_MFLO, MN_NOR: begin
            if (rd == '0) begin
               alias_kind_in = ALIAS_NOP;
            end
         end
         MN_ADD, MN_ADDU: begin
            priority if (rd == '0 || (rd == rs && rs != '0 && rt == '0)) begin
               alias_kind_in = ALIAS_NOP;
            end else if (rs == '0 && rt == '0) begin
               alias_kind_in = ALIAS_MOVE;
               alias_dest_in = rd;
            end else if (rs == '0) begin
               alias_kind_in   = ALIAS_MOVE;
               alias_dest_in   = rd;
               alias_source_in = rt;
            end else if (rt == '0) begin
               alias_kind_in   = ALIAS_MOVE;
               alias_dest_in   = rd;
               alias_source_in = rs;
            end else begin
               alias_kind_in = ALIAS_NONE;
            end
         end
         MN_SUB, MN_SUBU: begin
            priority if (rd == '0 || (rd == rs && rs != '0 && rt == '0)) begin
               alias_kind_in = ALIAS_NOP;
            end else if (rs == rt) begin
               alias_kind_in = ALIAS_MOVE;
               alias_dest_in = rd;
            end else if (rt == '0) begin
               alias_kind_in   = ALIAS_MOVE;
               alias_dest_in   = rd;
               alias_source_in = rs;
            end else begin
               alias_kind_in = ALIAS_NONE;
            end
         end
         MN_AND: begin
            priority if (rd == '0 || (rd == rs && rs == rt)) begin
               alias_kind_in = ALIAS_NOP;
            end else if (rs == '0 || rt == '0) begin
               alias_kind_in = ALIAS_MOVE;
               alias_dest_in = rd;
            end else if (rs == rt) begin
               alias_kind_in   = ALIAS_MOVE;
               alias_dest_in   = rd;
               alias_source_in = rs;
            end else begin
               alias_kind_in = ALIAS_NONE;
            end
         end
         MN_OR: begin
            priority if (rd == '0 || (rd == rs && (rt == rs || rt == '0))
                         || (rd == rt && (rs == rt || rs == '0))) begin
               alias_kind_in = ALIAS_NOP;
            end else if (rs == rt) begin
               alias_kind_in   = ALIAS_MOVE;
               alias_dest_in   = rd;
               alias_source_in = rs;
            end else if (rs == '0) begin
               alias_kind_in   = ALIAS_MOVE;
               alias_dest_in   = rd;
               alias_source_in = rt;
            end else if (rt == '0) begin
               alias_kind_in   = ALIAS_MOVE;
               alias_dest_in   = rd;
               alias_source_in = rs;
            end else begin
               alias_kind_in = ALIAS_NONE;
            end
         end
         MN_XOR: begin
            priority if (rd == '0 || (rd == rs && rt == '0) || (rd == rt && rs == '0)) begin
               alias_kind_in = ALIAS_NOP;
            end else if (rs == rt) begin
               alias_kind_in = ALIAS_MOVE;
               alias_dest_in = rd;
            end else begin
               alias_kind_in = ALIAS_NONE;
            end
         end
         MN_SLT: begin
            priority if (rd == '0) begin
               alias_kind_in = ALIAS_NOP;
            end else if (rs == rt) begin
               alias_kind_in = ALIAS_MOVE;
               alias_dest_in = rd;
            end else begin
               alias_kind_in = ALIAS_NONE;
            end
         end
         MN_BEQ: begin
            if (rs == rt) begin
               alias_kind_in = ALIAS_B;
            end
         end
         MN_BNE: begin
            if (rs == rt) begin
               alias_kind_in = ALIAS_NOPDS;
            end
         end
         MN_ADDI, MN_ADDIU: begin
            priority if (rt == '0) begin
               alias_kind_in = ALIAS_NOP;
            end else if (imm_zero) begin
               alias_kind_in   = ALIAS_MOVE;
               alias_dest_in   = rt;
               alias_source_in = rs;
            end else if (rs == '0) begin
               alias_kind_in = ALIAS_LI;
               alias_dest_in = rt;
            end else begin
               alias_kind_in = ALIAS_NONE;
            end
         end
         MN_SLTI: begin
            priority if (rt == '0) begin
               alias_kind_in = ALIAS_NOP;
            end else if (rs == '0 && imm_zero) begin
               alias_kind_in = ALIAS_MOVE;
               alias_dest_in = rt;
            end else begin
               alias_kind_in = ALIAS_NONE;
            end
         end
         MN_ANDI: begin
            priority if (rt == '0) begin
               alias_kind_in = ALIAS_NOP;
            end else if (imm_zero) begin
               alias_kind_in = ALIAS_MOVE;
               alias_dest_in = rt;
            end else begin
               alias_kind_in = ALIAS_NONE;
            end
         end
         MN_ORI: begin
            priority if (rt == '0 || (rs == rt && imm_zero)) begin
               alias_kind_in = ALIAS_NOP;
            end else if (imm_zero) begin
               alias_kind_in   = ALIAS_MOVE;
               alias_dest_in   = rt;
               alias_source_in = rs;
            end else begin
               alias_kind_in = ALIAS_NONE;
            end
         end
         MN_LUI: begin
            if (rt == '0) begin
               alias_kind_in = ALIAS_NOP;
            end
         end
         default: begin
            alias_kind_in = ALIAS_NONE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (rsp_load && s1_valid_ff) begin
         recognised_ff   <= recognised_in;
         mnemonic_ff     <= mnemonic_in;
         alias_kind_ff   <= alias_kind_in;
         alias_dest_ff   <= alias_dest_in;
         alias_source_ff <= alias_source_in;
         reg_s_ff        <= rs;
         reg_t_ff        <= rt;
         reg_d_ff        <= rd;
         shift_amount_ff <= sh;
         immediate_ff    <= $signed(instr_ff[15:0]);
         jump_target_ff  <= jump_target_in;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.recognised   = recognised_ff;
   assign rsp_chan.mnemonic     = mnemonic_ff;
   assign rsp_chan.alias_kind   = alias_kind_ff;
   assign rsp_chan.alias_dest   = alias_dest_ff;
   assign rsp_chan.alias_source = alias_source_ff;
   assign rsp_chan.reg_s        = reg_s_ff;
   assign rsp_chan.reg_t        = reg_t_ff;
   assign rsp_chan.reg_d        = reg_d_ff;
   assign rsp_chan.shift_amount = shift_amount_ff;
   assign rsp_chan.immediate    = immediate_ff;
   assign rsp_chan.jump_target  = jump_target_ff;

   `MDAC_ASSERT_ALWAYS(a_reset_empties, clock, reset |=> !rsp_valid_ff && !s1_valid_ff, "reset left a beat in the pipeline")
   `MDAC_ASSERT(a_advance, clock, reset, s1_valid_ff && rsp_load |=> rsp_valid_ff, "held beat did not advance to the result register")
   `MDAC_ASSERT(a_accept_fills, clock, reset, req_fire |=> s1_valid_ff, "accepted beat lost at the input register")
   `MDAC_ASSERT(a_unknown_clear, clock, reset, rsp_valid_ff && !recognised_ff |-> mnemonic_ff == '0 && alias_kind_ff == ALIAS_NONE, "unrecognised beat carries a mnemonic or alias")
   `MDAC_ASSERT(a_alias_regs, clock, reset, rsp_valid_ff && alias_source_ff != '0 |-> alias_kind_ff == ALIAS_MOVE, "alias source set outside a move alias")

endmodule

`default_nettype wire

@@ tb/mips32_decode_alias_classifier_tb.sv @@
// Self-checking testbench for the MIPS32 decode and alias classifier.
// Uses mdac_pkg and the mdac_req_if/mdac_rsp_if channels; predicts every decoded
// beat in-line and checks rsp_chan against it under random idling on both sides.
`timescale 1ns / 100ps
`default_nettype none

module mips32_decode_alias_classifier_tb;
   import mdac_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 100000;
   localparam int unsigned QUIET_FROM  = 1000;
   localparam int unsigned QUIET_TO    = 1700;
   localparam int unsigned RANDOM_WORDS = 1900;
   localparam int unsigned DRAIN_CYCLES = 8;

   typedef struct packed {
      logic                recognised;
      mnemonic_type        mnemonic;
      alias_type           alias_kind;
      reg_type             alias_dest;
      reg_type             alias_source;
      reg_type             reg_s;
      reg_type             reg_t;
      reg_type             reg_d;
      reg_type             shift_amount;
      logic [IMM_W-1:0]    immediate;
      logic [TARGET_W-1:0] jump_target;
   } decoded_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   mdac_req_if req_chan ();
   mdac_rsp_if rsp_chan ();

   mips32_decode_alias_classifier uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   logic [WORD_W-1:0] word_q[$];
   decoded_t          decoded_q[$];
   int unsigned       cycle_count = 0;
   int unsigned       fault_count = 0;
   logic              req_taken = 1'b0;

   const code_type fn_list[21] = '{
      FN_SLL, FN_SRL, FN_SRA, FN_JR, FN_MFHI, FN_MTHI, FN_MFLO, FN_MTLO,
      FN_MULT, FN_MULTU, FN_DIV, FN_DIVU, FN_ADD, FN_ADDU, FN_SUB, FN_SUBU,
      FN_AND, FN_OR, FN_XOR, FN_NOR, FN_SLT
   };
   const code_type op_list[18] = '{
      OP_J, OP_JAL, OP_BEQ, OP_BNE, OP_ADDI, OP_ADDIU, OP_SLTI, OP_ANDI,
      OP_ORI, OP_LUI, OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU, OP_SB, OP_SH, OP_SW
   };

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic decoded_t decode_word(input logic [WORD_W-1:0] w);
      decoded_t     r;
      code_type     op;
      code_type     fn;
      mnemonic_type mn;
      reg_type      s;
      reg_type      t;
      reg_type      d;
      logic         imm_zero;
      alias_type    kind;
      reg_type      dst;
      reg_type      src;
      op = w[31:26];
      fn = w[5:0];
      s  = w[25:21];
      t  = w[20:16];
      d  = w[15:11];
      imm_zero = (w[15:0] == '0);
      mn = MN_UNKNOWN;
      if (op == OP_SPECIAL) begin
         case (fn)
            FN_SLL:   mn = MN_SLL;
            FN_SRL:   mn = MN_SRL;
            FN_SRA:   mn = MN_SRA;
            FN_JR:    mn = MN_JR;
            FN_MFHI:  mn = MN_MFHI;
            FN_MTHI:  mn = MN_MTHI;
            FN_MFLO:  mn = MN_MFLO;
            FN_MTLO:  mn = MN_MTLO;
            FN_MULT:  mn = MN_MULT;
            FN_MULTU: mn = MN_MULTU;
            FN_DIV:   mn = MN_DIV;
            FN_DIVU:  mn = MN_DIVU;
            FN_ADD:   mn = MN_ADD;
            FN_ADDU:  mn = MN_ADDU;
            FN_SUB:   mn = MN_SUB;
            FN_SUBU:  mn = MN_SUBU;
            FN_AND:   mn = MN_AND;
            FN_OR:    mn = MN_OR;
            FN_XOR:   mn = MN_XOR;
            FN_NOR:   mn = MN_NOR;
            FN_SLT:   mn = MN_SLT;
            default:  mn = MN_UNKNOWN;
         endcase
      end else begin
         case (op)
            OP_J:     mn = MN_J;
            OP_JAL:   mn = MN_JAL;
            OP_BEQ:   mn = MN_BEQ;
            OP_BNE:   mn = MN_BNE;
            OP_ADDI:  mn = MN_ADDI;
            OP_ADDIU: mn = MN_ADDIU;
            OP_SLTI:  mn = MN_SLTI;
            OP_ANDI:  mn = MN_ANDI;
            OP_ORI:   mn = MN_ORI;
            OP_LUI:   mn = MN_LUI;
            OP_LB:    mn = MN_LB;
            OP_LH:    mn = MN_LH;
            OP_LW:    mn = MN_LW;
            OP_LBU:   mn = MN_LBU;
            OP_LHU:   mn = MN_LHU;
            OP_SB:    mn = MN_SB;
            OP_SH:    mn = MN_SH;
            OP_SW:    mn = MN_SW;
            default:  mn = MN_UNKNOWN;
         endcase
      end

      kind = ALIAS_NONE;
      dst  = '0;
      src  = '0;
      case (mn)
         MN_SLL, MN_SRL, MN_SRA: begin
            if (d == 0) kind = ALIAS_NOP;
            else if (t == 0) begin kind = ALIAS_MOVE; dst = d; end
         end
         MN_MFHI, MN_MFLO, MN_NOR: begin
            if (d == 0) kind = ALIAS_NOP;
         end
         MN_ADD, MN_ADDU: begin
            if (d == 0 || (d == s && s != 0 && t == 0)) kind = ALIAS_NOP;
            else if (s == 0 && t == 0) begin kind = ALIAS_MOVE; dst = d; end
            else if (s == 0) begin kind = ALIAS_MOVE; dst = d; src = t; end
            else if (t == 0) begin kind = ALIAS_MOVE; dst = d; src = s; end
         end
         MN_SUB, MN_SUBU: begin
            if (d == 0 || (d == s && s != 0 && t == 0)) kind = ALIAS_NOP;
            else if (s == t) begin kind = ALIAS_MOVE; dst = d; end
            else if (t == 0) begin kind = ALIAS_MOVE; dst = d; src = s; end
         end
         MN_AND: begin
            if (d == 0 || (d == s && s == t)) kind = ALIAS_NOP;
            else if (s == 0 || t == 0) begin kind = ALIAS_MOVE; dst = d; end
            else if (s == t) begin kind = ALIAS_MOVE; dst = d; src = s; end
         end
         MN_OR: begin
            if (d == 0 || (d == s && (t == s || t == 0)) ||
                (d == t && (s == t || s == 0))) kind = ALIAS_NOP;
            else if (s == t) begin kind = ALIAS_MOVE; dst = d; src = s; end
            else if (s == 0) begin kind = ALIAS_MOVE; dst = d; src = t; end
            else if (t == 0) begin kind = ALIAS_MOVE; dst = d; src = s; end
         end
         MN_XOR: begin
            if (d == 0 || (d == s && t == 0) || (d == t && s == 0)) kind = ALIAS_NOP;
            else if (s == t) begin kind = ALIAS_MOVE; dst = d; end
         end
         MN_SLT: begin
            if (d == 0) kind = ALIAS_NOP;
            else if (s == t) begin kind = ALIAS_MOVE; dst = d; end
         end
         MN_BEQ: begin
            if (s == t) kind = ALIAS_B;
         end
         MN_BNE: begin
            if (s == t) kind = ALIAS_NOPDS;
         end
         MN_ADDI, MN_ADDIU: begin
            if (t == 0) kind = ALIAS_NOP;
            else if (imm_zero) begin kind = ALIAS_MOVE; dst = t; src = s; end
            else if (s == 0) begin kind = ALIAS_LI; dst = t; end
         end
         MN_SLTI: begin
            if (t == 0) kind = ALIAS_NOP;
            else if (s == 0 && imm_zero) begin kind = ALIAS_MOVE; dst = t; end
         end
         MN_ANDI: begin
            if (t == 0) kind = ALIAS_NOP;
            else if (imm_zero) begin kind = ALIAS_MOVE; dst = t; end
         end
         MN_ORI: begin
            if (t == 0 || (s == t && imm_zero)) kind = ALIAS_NOP;
            else if (imm_zero) begin kind = ALIAS_MOVE; dst = t; src = s; end
         end
         MN_LUI: begin
            if (t == 0) kind = ALIAS_NOP;
         end
         default: ;
      endcase

      r.recognised   = (mn != MN_UNKNOWN);
      r.mnemonic     = r.recognised ? mn : '0;
      r.alias_kind   = kind;
      r.alias_dest   = dst;
      r.alias_source = src;
      r.reg_s        = s;
      r.reg_t        = t;
      r.reg_d        = d;
      r.shift_amount = w[10:6];
      r.immediate    = w[15:0];
      r.jump_target  = {w[25:0], 2'b00};
      return r;
   endfunction

   function automatic logic [WORD_W-1:0] rword(code_type fn, reg_type s, reg_type t,
                                                reg_type d, reg_type sh);
      return {OP_SPECIAL, s, t, d, sh, fn};
   endfunction

   function automatic logic [WORD_W-1:0] iword(code_type op, reg_type s, reg_type t,
                                                logic [IMM_W-1:0] imm);
      return {op, s, t, imm};
   endfunction

   // bias register picks toward zero and one shared value so aliases fire often
   function automatic reg_type pick_reg(reg_type shared);
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 35) return '0;
      if (roll < 70) return shared;
      return reg_type'($urandom_range(31));
   endfunction

   function automatic logic [IMM_W-1:0] pick_imm();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 25) return '0;
      if (roll < 30) return 16'h7FFF;
      if (roll < 35) return 16'h8000;
      if (roll < 40) return 16'hFFFF;
      return IMM_W'($urandom);
   endfunction

   function automatic logic [WORD_W-1:0] random_word();
      int unsigned pick;
      reg_type     shared;
      reg_type     sh;
      code_type    op;
      if ($urandom_range(99) < 15) return $urandom;
      pick   = $urandom_range(38);
      shared = reg_type'($urandom_range(31));
      sh     = ($urandom_range(3) == 0) ? reg_type'($urandom_range(31)) : '0;
      if (pick < 21)
         return rword(fn_list[pick], pick_reg(shared), pick_reg(shared),
                      pick_reg(shared), sh);
      op = op_list[pick - 21];
      if (op == OP_J || op == OP_JAL)
         return {op, 26'($urandom)};
      return iword(op, pick_reg(shared), pick_reg(shared), pick_imm());
   endfunction

   function automatic logic idle_now();
      if (cycle_count >= QUIET_FROM && cycle_count < QUIET_TO) return 1'b0;
      return $urandom_range(99) < 19;
   endfunction

   task automatic check_field(string name, logic signed [31:0] exp_v,
                              logic signed [31:0] act_v);
      if (act_v !== exp_v) begin
         $error("%s: expected %0d actual %0d", name, exp_v, act_v);
         fault_count++;
      end
   endtask

   // driver: hold the beat until accepted, then advance or idle
   always @(negedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (req_chan.valid && !req_taken) begin
         req_chan.valid <= 1'b1;
      end else if (word_q.size() != 0 && !idle_now()) begin
         req_chan.valid       <= 1'b1;
         req_chan.instruction <= word_q.pop_front();
      end else begin
         req_chan.valid <= 1'b0;
      end
   end

   always @(negedge clock) begin
      rsp_chan.ready <= !reset && !idle_now();
   end

   always @(posedge clock) begin
      req_taken <= !reset && req_chan.valid && req_chan.ready;
      if (!reset && req_chan.valid && req_chan.ready)
         decoded_q.push_back(decode_word(req_chan.instruction));
   end

   // monitor: compare each result beat with the oldest prediction
   always @(posedge clock) begin
      decoded_t exp_r;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (decoded_q.size() == 0) begin
            $error("result beat with no prediction pending");
            fault_count++;
         end else begin
            exp_r = decoded_q.pop_front();
            check_field("recognised", exp_r.recognised, rsp_chan.recognised);
            check_field("mnemonic", exp_r.mnemonic, rsp_chan.mnemonic);
            check_field("alias_kind", exp_r.alias_kind, rsp_chan.alias_kind);
            check_field("alias_dest", exp_r.alias_dest, rsp_chan.alias_dest);
            check_field("alias_source", exp_r.alias_source, rsp_chan.alias_source);
            check_field("reg_s", exp_r.reg_s, rsp_chan.reg_s);
            check_field("reg_t", exp_r.reg_t, rsp_chan.reg_t);
            check_field("reg_d", exp_r.reg_d, rsp_chan.reg_d);
            check_field("shift_amount", exp_r.shift_amount, rsp_chan.shift_amount);
            check_field("immediate", $signed(exp_r.immediate),
                        $signed(rsp_chan.immediate));
            check_field("jump_target", exp_r.jump_target, rsp_chan.jump_target);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      req_chan.valid       = 1'b0;
      req_chan.instruction = '0;
      rsp_chan.ready       = 1'b0;

      word_q.push_back(32'h0000_0000);
      word_q.push_back(32'hFFFF_FFFF);
      word_q.push_back(rword(FN_SLL, 5'd3, 5'd0, 5'd5, 5'd31));
      word_q.push_back(rword(FN_SRA, 5'd31, 5'd4, 5'd31, 5'd1));
      word_q.push_back(rword(FN_ADD, 5'd6, 5'd0, 5'd6, 5'd0));
      word_q.push_back(rword(FN_ADDU, 5'd0, 5'd0, 5'd9, 5'd0));
      word_q.push_back(rword(FN_ADDU, 5'd0, 5'd7, 5'd9, 5'd0));
      word_q.push_back(rword(FN_SUB, 5'd8, 5'd8, 5'd2, 5'd0));
      word_q.push_back(rword(FN_AND, 5'd4, 5'd4, 5'd11, 5'd0));
      word_q.push_back(rword(FN_OR, 5'd0, 5'd12, 5'd12, 5'd0));
      word_q.push_back(rword(FN_OR, 5'd13, 5'd13, 5'd14, 5'd0));
      word_q.push_back(rword(FN_XOR, 5'd15, 5'd15, 5'd16, 5'd0));
      word_q.push_back(rword(FN_SLT, 5'd17, 5'd17, 5'd18, 5'd0));
      word_q.push_back(rword(6'h01, 5'd1, 5'd2, 5'd3, 5'd4));
      word_q.push_back(iword(OP_BEQ, 5'd5, 5'd5, 16'h8000));
      word_q.push_back(iword(OP_BNE, 5'd0, 5'd0, 16'h7FFF));
      word_q.push_back(iword(OP_ADDI, 5'd3, 5'd0, 16'h1234));
      word_q.push_back(iword(OP_ADDIU, 5'd21, 5'd22, 16'h0000));
      word_q.push_back(iword(OP_ADDIU, 5'd0, 5'd23, 16'hFFFF));
      word_q.push_back(iword(OP_SLTI, 5'd0, 5'd24, 16'h0000));
      word_q.push_back(iword(OP_ANDI, 5'd25, 5'd26, 16'h0000));
      word_q.push_back(iword(OP_ORI, 5'd27, 5'd27, 16'h0000));
      word_q.push_back(iword(OP_ORI, 5'd28, 5'd29, 16'h0000));
      word_q.push_back(iword(OP_LUI, 5'd1, 5'd0, 16'hABCD));
      word_q.push_back(iword(OP_LW, 5'd29, 5'd31, 16'h8000));
      word_q.push_back({OP_J, 26'h3FF_FFFF});
      word_q.push_back({OP_JAL, 26'h000_0000});
      word_q.push_back({6'h3F, 26'h155_5555});
      for (int unsigned i = 0; i < RANDOM_WORDS; i++)
         word_q.push_back(random_word());

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      while (word_q.size() != 0 || req_chan.valid) @(posedge clock);
      while (decoded_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fault_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

`default_nettype wire

@@ mips32_decode_alias_classifier.f @@
+incdir+rtl/core
rtl/core/mdac_pkg.sv
rtl/core/mdac_if.sv
rtl/core/mips32_decode_alias_classifier.sv
tb/mips32_decode_alias_classifier_tb.sv
